/* sv/daily_alarm_bank_defines.svh */
// Assertion macros for the alarm bank.
`ifndef DAILY_ALARM_BANK_DEFINES_SVH
`define DAILY_ALARM_BANK_DEFINES_SVH
`ifndef SYNTHESIS
`define DAB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DAB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/dab_pkg.sv */
package dab_pkg;

  localparam int TIME_W = 27;
  localparam int TMO_W  = 16;
  localparam int CNT_W  = 8;
  localparam int WAIT_W = 32;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_OPEN    = 3'd1;
  localparam logic [2:0] ACT_PGM_ABS = 3'd2;
  localparam logic [2:0] ACT_PGM_REL = 3'd3;
  localparam logic [2:0] ACT_DISABLE = 3'd4;

  // Which pass the datapath runs over the current alarm.
  typedef enum logic [2:0] {
    OP_UPDATE = 3'b001,
    OP_SCAN   = 3'b010,
    OP_NONE   = 3'b100
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   load;
    logic   clear;
    logic   fin;
    dp_op_t op;
  } dp_cmd_t;

endpackage

/* sv/dab_ctrl.sv */
module dab_ctrl #(
  parameter int ALARMS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output dab_pkg::dp_cmd_t  cmd,
  output logic [((ALARMS > 1) ? $clog2(ALARMS) : 1)-1:0] idx
);
  import dab_pkg::*;

  localparam int IW = (ALARMS > 1) ? $clog2(ALARMS) : 1;
  localparam logic [IW-1:0] LAST = IW'(ALARMS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  // Sequence: update each alarm, then scan each alarm, then publish.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '{load: 1'b0, clear: 1'b0, fin: 1'b0, op: OP_NONE};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
          idx_nxt   = '0;
        end
      end
      S_UPD: begin
        cmd.op = OP_UPDATE;
        if (idx_r == LAST) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          cmd.clear = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (idx_r == LAST) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign idx  = idx_r;

endmodule

/* sv/dab_dp.sv */
module dab_dp #(
  parameter int ALARMS     = 8,
  parameter int DISPENSERS = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dab_pkg::dp_cmd_t    cmd,
  input  logic [((ALARMS > 1) ? $clog2(ALARMS) : 1)-1:0] idx,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic [2:0]          in_action,
  input  logic [26:0]         in_time_ms,
  input  logic [2:0]          in_alarm_index,
  input  logic                in_dispenser,
  input  logic [26:0]         in_target_ms,
  input  logic [7:0]          in_per_day,
  output logic                out_valid,
  output logic [7:0]          out_ringing_mask,
  output logic [1:0]          out_dispenser_alarm,
  output logic [7:0]          out_started_mask,
  output logic [7:0]          out_missed_mask,
  output logic                out_open_beep,
  output logic                out_next_valid,
  output logic [2:0]          out_next_alarm,
  output logic [31:0]         out_next_wait_ms
);
  import dab_pkg::*;

  localparam int AI = (ALARMS > 1) ? $clog2(ALARMS) : 1;

  // Configuration register.
  logic [TMO_W-1:0] tmo_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tmo_cfg_r <= TMO_W'(120);
    else if (cfg_we) tmo_cfg_r <= cfg_wdata;
  end

  // Captured transaction.
  logic [2:0]        act_r;
  logic [TIME_W-1:0] now_r, tgt_r;
  logic [2:0]        aidx_r;
  logic              disp_r;
  logic [CNT_W-1:0]  perday_r;
  logic              midnight_r;
  logic [TIME_W-1:0] prev_r;

  // Per-alarm state.
  logic [ALARMS-1:0] on_r, ring_r, owner_r, rel_r, done_r, never_r;
  logic [TIME_W-1:0] target_r [ALARMS];
  logic [TIME_W-1:0] last_r   [ALARMS];
  logic [CNT_W-1:0]  limit_r  [ALARMS];
  logic [CNT_W-1:0]  rings_r  [ALARMS];
  logic [TMO_W-1:0]  tmo_r    [ALARMS];

  logic [ALARMS-1:0] started_r, missed_r;
  logic [WAIT_W-1:0] best_r;
  logic [AI-1:0]     best_i_r;
  logic              bvalid_r;

  logic [AI-1:0] ai;
  assign ai = idx[AI-1:0];

  // Next state of the current alarm for the update pass.
  logic              on_nxt, ring_nxt, owner_nxt, rel_nxt, done_nxt, never_nxt;
  logic [TIME_W-1:0] target_nxt, last_nxt;
  logic [CNT_W-1:0]  limit_nxt, rings_nxt;
  logic [TMO_W-1:0]  tmo_nxt;
  logic              start_nxt, miss_nxt;
  logic              hit, due;
  logic [TIME_W-1:0] el;

  always_comb begin
    on_nxt = on_r[ai]; ring_nxt = ring_r[ai]; owner_nxt = owner_r[ai];
    rel_nxt = rel_r[ai]; done_nxt = done_r[ai]; never_nxt = never_r[ai];
    target_nxt = target_r[ai]; last_nxt = last_r[ai]; limit_nxt = limit_r[ai];
    rings_nxt = rings_r[ai]; tmo_nxt = tmo_r[ai];
    start_nxt = 1'b0; miss_nxt = 1'b0; due = 1'b0; el = '0;
    hit = (32'(aidx_r) == 32'(idx)) && (32'(aidx_r) < ALARMS);
    priority case (1'b1)
      act_r == ACT_TICK: begin
        // Timeout countdown.
        if (on_nxt && ring_nxt) begin
          if (tmo_nxt <= TMO_W'(1)) begin
            ring_nxt = 1'b0; tmo_nxt = '0; miss_nxt = 1'b1;
          end else begin
            tmo_nxt = tmo_nxt - 1'b1;
          end
        end
        // Midnight reset.
        if (midnight_r && on_nxt) begin
          ring_nxt = 1'b0; tmo_nxt = '0;
          if (rel_nxt) begin
            rings_nxt = '0; never_nxt = 1'b1;
          end else begin
            done_nxt = 1'b0;
          end
        end
        // Start a due alarm.
        el = now_r - last_nxt;
        if (on_nxt && !ring_nxt) begin
          if (!rel_nxt) due = (now_r >= target_nxt) && !done_nxt;
          else due = !never_nxt && (rings_nxt < limit_nxt) && (now_r > last_nxt) &&
                     (el > target_nxt);
        end
        if (due) begin
          ring_nxt = 1'b1;
          if (rel_nxt) begin
            rings_nxt = rings_nxt + 1'b1; last_nxt = now_r;
          end else begin
            done_nxt = 1'b1;
          end
          tmo_nxt = tmo_cfg_r;
          start_nxt = 1'b1;
        end
      end
      act_r == ACT_OPEN: begin
        if (on_nxt && (owner_nxt == disp_r)) begin
          if (ring_nxt) begin
            ring_nxt = 1'b0; tmo_nxt = '0;
          end else if (rel_nxt && (rings_nxt == '0)) begin
            last_nxt = now_r; never_nxt = 1'b0;
          end
        end
      end
      (act_r == ACT_PGM_ABS || act_r == ACT_PGM_REL): begin
        if (hit && (32'(disp_r) < DISPENSERS)) begin
          on_nxt = 1'b1; ring_nxt = 1'b0; tmo_nxt = '0; owner_nxt = disp_r;
          target_nxt = tgt_r;
          if (act_r == ACT_PGM_ABS) begin
            rel_nxt = 1'b0; done_nxt = 1'b0;
          end else begin
            rel_nxt = 1'b1; limit_nxt = perday_r; rings_nxt = '0; never_nxt = 1'b1;
          end
        end
      end
      act_r == ACT_DISABLE: begin
        if (hit) begin
          on_nxt = 1'b0; ring_nxt = 1'b0; tmo_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // Wait of the current alarm for the scan pass.
  logic [WAIT_W-1:0] w;
  logic [TIME_W-1:0] el_s;
  always_comb begin
    el_s = now_r - last_r[ai];
    if (!rel_r[ai]) begin
      w = done_r[ai] ? '1 : (WAIT_W'(target_r[ai]) - WAIT_W'(now_r));
    end else if (never_r[ai]) begin
      w = '0;
    end else if ((rings_r[ai] < limit_r[ai]) && (now_r > last_r[ai])) begin
      w = WAIT_W'(target_r[ai]) - WAIT_W'(el_s);
    end else begin
      w = '1;
    end
  end

  // Output masks from the flags.
  logic [ALARMS-1:0] ringm;
  logic [1:0]        dm;
  always_comb begin
    dm = '0;
    ringm = on_r & ring_r;
    for (int i = 0; i < ALARMS; i++) begin
      if (ringm[i]) dm[owner_r[i]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r <= '0; ring_r <= '0; owner_r <= '0; rel_r <= '0; done_r <= '0;
      never_r <= '0; prev_r <= '0; out_valid <= 1'b0;
      for (int i = 0; i < ALARMS; i++) begin
        target_r[i] <= '0; last_r[i] <= '0; limit_r[i] <= '0;
        rings_r[i] <= '0; tmo_r[i] <= '0;
      end
    end else begin
      out_valid <= cmd.fin;
      if (cmd.load) begin
        act_r <= in_action; now_r <= in_time_ms; aidx_r <= in_alarm_index;
        disp_r <= in_dispenser; tgt_r <= in_target_ms; perday_r <= in_per_day;
        midnight_r <= (in_action == ACT_TICK) && (prev_r > in_time_ms);
        if (in_action == ACT_TICK) prev_r <= in_time_ms;
        started_r <= '0; missed_r <= '0;
      end
      if (cmd.op == OP_UPDATE) begin
        on_r[ai] <= on_nxt; ring_r[ai] <= ring_nxt; owner_r[ai] <= owner_nxt;
        rel_r[ai] <= rel_nxt; done_r[ai] <= done_nxt; never_r[ai] <= never_nxt;
        target_r[ai] <= target_nxt; last_r[ai] <= last_nxt;
        limit_r[ai] <= limit_nxt; rings_r[ai] <= rings_nxt; tmo_r[ai] <= tmo_nxt;
        started_r[ai] <= start_nxt; missed_r[ai] <= miss_nxt;
      end
      if (cmd.clear) begin
        best_r <= '1; best_i_r <= '0; bvalid_r <= 1'b0;
      end
      if (cmd.op == OP_SCAN && on_r[ai] && (w < best_r)) begin
        best_r <= w; best_i_r <= ai; bvalid_r <= 1'b1;
      end
      if (cmd.fin) begin
        out_ringing_mask    <= 8'(ringm);
        out_dispenser_alarm <= dm;
        out_started_mask    <= 8'(started_r);
        out_missed_mask     <= 8'(missed_r);
        out_open_beep       <= (act_r == ACT_OPEN);
        out_next_valid      <= bvalid_r;
        out_next_alarm      <= 3'(best_i_r);
        out_next_wait_ms    <= best_r;
      end
    end
  end

endmodule

/* sv/daily_alarm_bank.sv */
// Daily alarm bank.
// Input channel: present an item on the in_ ports with start high while busy
// is low; the transaction is taken at that clock edge. busy then stays high
// until the result has been produced.
// Each item runs from the accepting edge through an update pass over the
// alarms, one per cycle, a second pass that scans them one per cycle for
// the next alarm, and a final state that publishes the result and raises
// out_valid. busy falls together with the out_valid strobe, so the next item
// can be accepted at the edge that ends the strobe; a new item is not taken
// before the last one is through.
// Result channel: the out_ ports hold one result, marked by out_valid for
// exactly one cycle; the receiver cannot stall it and must take it then.
// Configuration: cfg_we with cfg_wdata writes the ring timeout in ticks;
// write it only while busy is low.
// Reset: synchronous, active low; clears all alarms, the previous tick time
// and sets the ring timeout to 120 ticks.
`include "daily_alarm_bank_defines.svh"
module daily_alarm_bank #(
  parameter int ALARMS     = 8,
  parameter int DISPENSERS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [2:0]  in_action,
  input  logic [26:0] in_time_ms,
  input  logic [2:0]  in_alarm_index,
  input  logic        in_dispenser,
  input  logic [26:0] in_target_ms,
  input  logic [7:0]  in_per_day,
  output logic        out_valid,
  output logic [7:0]  out_ringing_mask,
  output logic [1:0]  out_dispenser_alarm,
  output logic [7:0]  out_started_mask,
  output logic [7:0]  out_missed_mask,
  output logic        out_open_beep,
  output logic        out_next_valid,
  output logic [2:0]  out_next_alarm,
  output logic [31:0] out_next_wait_ms
);
  import dab_pkg::*;

  dp_cmd_t cmd;
  logic [((ALARMS > 1) ? $clog2(ALARMS) : 1)-1:0] idx;

  dab_ctrl #(.ALARMS(ALARMS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .idx(idx)
  );

  dab_dp #(.ALARMS(ALARMS), .DISPENSERS(DISPENSERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .idx(idx),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_action(in_action), .in_time_ms(in_time_ms),
    .in_alarm_index(in_alarm_index), .in_dispenser(in_dispenser),
    .in_target_ms(in_target_ms), .in_per_day(in_per_day),
    .out_valid(out_valid), .out_ringing_mask(out_ringing_mask),
    .out_dispenser_alarm(out_dispenser_alarm), .out_started_mask(out_started_mask),
    .out_missed_mask(out_missed_mask), .out_open_beep(out_open_beep),
    .out_next_valid(out_next_valid), .out_next_alarm(out_next_alarm),
    .out_next_wait_ms(out_next_wait_ms)
  );

  // A strobe only comes at the end of a busy transaction.
  `DAB_ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, !$past(busy) == 1'b0)
  // An accepted transaction makes the block busy.
  `DAB_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  // With no alarm found the wait reads as all ones.
  `DAB_ASSERT_IMPL(a_none_wait, clk, rst_n, out_valid && !out_next_valid,
                   out_next_wait_ms == 32'hFFFF_FFFF)

endmodule
